// File: src/mwc_pkg.sv
package mwc_pkg;

    localparam int HOLD_DEPTH_DEF = 32;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        MODE_START       = 3'd0,
        MODE_TAG         = 3'd1,
        MODE_TAG_SPACE   = 3'd2,
        MODE_FIRST_SPACE = 3'd3,
        MODE_MORE_SPACE  = 3'd4,
        MODE_TEXT        = 3'd5
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic drain_step;
        logic tail_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic start_drain;
        logic has_tail;
        logic drain_last;
    } t_sts;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: src/mwc_ctrl.sv
module mwc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mwc_pkg::t_sts   i_sts,
    output mwc_pkg::t_cmd   o_cmd,
    output logic            o_stall
);
    import mwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DRAIN = 3'b010,
        S_TAIL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.drain_step = 1'b0;
        o_cmd.tail_step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.start_drain) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.drain_step = i_sts.out_free;
                if (i_sts.out_free && i_sts.drain_last) begin
                    n_state = i_sts.has_tail ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                o_cmd.tail_step = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = !((r_state == S_IDLE) && i_sts.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/mwc_dp.sv
module mwc_dp #(
    parameter int HOLD_DEPTH = mwc_pkg::HOLD_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mwc_pkg::t_cmd   i_cmd,
    output mwc_pkg::t_sts   o_sts,
    input  logic            i_kind,
    input  logic [7:0]      i_ch,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_overflow
);
    import mwc_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HOLD_DEPTH);

    logic [7:0]       r_mem [HOLD_DEPTH];
    logic [7:0]       r_rd;
    t_mode            r_mode;
    t_mode            n_mode;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       r_tail;
    logic             r_tail_ovf;
    logic             r_has_tail;
    logic             r_drain_ovf;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_ovf;

    logic       ws;
    logic       emit;
    logic [7:0] emit_byte;
    logic       start_drain;
    logic       has_tail;
    logic       drain_ovf;
    logic       wr;
    logic       clr;
    logic       out_free;
    logic       drain_last;

    assign ws         = is_ws(i_ch);
    assign out_free   = !r_out_valid || !i_stall;
    assign drain_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // per-item decode
    always_comb begin
        n_mode      = r_mode;
        emit        = 1'b0;
        emit_byte   = i_ch;
        start_drain = 1'b0;
        has_tail    = 1'b0;
        drain_ovf   = 1'b0;
        wr          = 1'b0;
        clr         = 1'b0;
        if (i_kind == KIND_FLUSH) begin
            start_drain = (r_count != '0);
        end else begin
            unique case (r_mode)
                MODE_START: begin
                    emit = 1'b1;
                    if (i_ch == CH_LT) begin
                        n_mode = MODE_TAG;
                    end else if (ws) begin
                        n_mode = MODE_FIRST_SPACE;
                    end
                end
                MODE_TAG: begin
                    emit = 1'b1;
                    if (ws) begin
                        emit_byte = CH_SPACE;
                        n_mode    = MODE_TAG_SPACE;
                    end else if (i_ch == CH_GT) begin
                        n_mode = MODE_FIRST_SPACE;
                    end
                end
                MODE_TAG_SPACE: begin
                    if (!ws) begin
                        emit   = 1'b1;
                        n_mode = (i_ch == CH_GT) ? MODE_FIRST_SPACE : MODE_TAG;
                    end
                end
                MODE_FIRST_SPACE, MODE_MORE_SPACE: begin
                    if (ws) begin
                        if (r_mode == MODE_FIRST_SPACE) begin
                            emit   = 1'b1;
                            n_mode = MODE_MORE_SPACE;
                        end
                    end else begin
                        emit   = 1'b1;
                        n_mode = (i_ch == CH_LT) ? MODE_TAG : MODE_TEXT;
                    end
                end
                MODE_TEXT: begin
                    if (ws) begin
                        if (r_count >= CNT_FULL) begin
                            start_drain = 1'b1;
                            has_tail    = 1'b1;
                            drain_ovf   = 1'b1;
                        end else begin
                            wr = 1'b1;
                        end
                    end else if (i_ch == CH_LT) begin
                        clr    = 1'b1;
                        emit   = 1'b1;
                        n_mode = MODE_TAG;
                    end else if (r_count != '0) begin
                        start_drain = 1'b1;
                        has_tail    = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: n_mode = MODE_START;
            endcase
        end
    end

    assign o_sts.out_free    = out_free;
    assign o_sts.start_drain = start_drain;
    assign o_sts.has_tail    = r_has_tail;
    assign o_sts.drain_last  = drain_last;

    // drain index, read address runs one ahead so r_rd holds entry r_idx whenever a drain step reads it
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.accept && start_drain) begin
            n_idx = '0;
        end else if (i_cmd.drain_step) begin
            n_idx = drain_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr) begin
            r_mem[r_count[IDX_W-1:0]] <= i_ch;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && start_drain) begin
            r_tail      <= i_ch;
            r_tail_ovf  <= drain_ovf;
            r_has_tail  <= has_tail;
            r_drain_ovf <= drain_ovf;
        end
        if (out_free) begin
            if (i_cmd.drain_step) begin
                r_out_byte <= r_rd;
                r_out_last <= drain_last && !r_has_tail;
                r_out_ovf  <= r_drain_ovf;
            end else if (i_cmd.tail_step) begin
                r_out_byte <= r_tail;
                r_out_last <= 1'b1;
                r_out_ovf  <= r_tail_ovf;
            end else begin
                r_out_byte <= emit_byte;
                r_out_last <= 1'b1;
                r_out_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_START;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.accept) begin
                r_mode <= n_mode;
            end
            if (i_cmd.accept && wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if ((i_cmd.accept && clr) || (i_cmd.drain_step && drain_last)) begin
                r_count <= '0;
            end
            if (out_free) begin
                r_out_valid <= (i_cmd.accept && emit) || i_cmd.drain_step
                               || i_cmd.tail_step;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_overflow = r_out_ovf;

endmodule

// File: src/markup_whitespace_compactor.sv
// markup whitespace compactor: a byte filter that squeezes whitespace out of markup text.
// inside a tag a whitespace run becomes one space, between tags only the first whitespace
// byte after a tag survives, and in text a run is held back (up to HOLD_DEPTH bytes) and
// dropped before '<' or released ahead of the next text byte; a flush item releases it.
// plain bytes pass at one item per cycle while the output side keeps up and no held run
// is going out. an item that releases a held run is taken, then the run leaves the hold
// memory through its single read port one byte per cycle while the output keeps up, then
// the byte after the run if any; input is stalled meanwhile. every result of an item
// carries last on its final byte, and bytes released by a full hold buffer carry overflow.
module markup_whitespace_compactor #(
    parameter int HOLD_DEPTH = mwc_pkg::HOLD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_ch,
    // result item channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_overflow
);
    import mwc_pkg::*;

    // command and status between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // controller: idle / drain held run / emit byte that follows the run
    mwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // datapath: mode register, hold memory, drain index and output register
    mwc_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_kind     (i_kind),
        .i_ch       (i_ch),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

`ifndef SYNTHESIS
    // input stays blocked while a held run goes out
    a_stall_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.drain_step || cmd.tail_step) |-> o_stall)
        else $error("input item taken while held run is emitted");

    // an item that releases a run starts emitting it on the next cycle
    a_drain_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.start_drain) |=> cmd.drain_step)
        else $error("held run drain did not start");

    // after the byte that follows a run, input opens as soon as output drains
    a_tail_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.tail_step |=> (o_stall == i_stall))
        else $error("controller did not return to idle after tail byte");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
    import mwc_pkg::*;

    localparam int HOLD         = HOLD_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 224;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_CYCLES  = 2 * HOLD + 16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_out_item;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_BYTE
    } t_chk;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [5:0] reps;
        t_chk       chk;
        logic [7:0] exp;
    } t_stim_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       i_kind     = KIND_CHAR;
    logic [7:0] i_ch       = 8'h00;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       o_overflow;

    // check mode travels with the item
    t_chk       item_chk = CHK_MODEL;
    logic [7:0] item_exp = 8'h00;

    // squeezer state as seen by the predictor
    t_mode      sq_mode = MODE_START;
    logic [7:0] run_buf [HOLD];
    int         run_len = 0;

    t_out_item  step_out[$];
    t_out_item  expected_bytes[$];
    int         err_cnt    = 0;
    int         cycle_cnt  = 0;
    int         items_sent = 0;
    int         calm_left  = 0;

    localparam t_stim_row DIR_TAB [26] = '{
        '{KIND_CHAR,  8'h61, 6'd1,  CHK_BYTE,  8'h61},  // plain byte from start
        '{KIND_CHAR,  8'h00, 6'd1,  CHK_BYTE,  8'h00},
        '{KIND_CHAR,  8'hFF, 6'd1,  CHK_BYTE,  8'hFF},
        '{KIND_FLUSH, 8'h00, 6'd1,  CHK_NONE,  8'h00},  // flush with nothing held
        '{KIND_CHAR,  8'h08, 6'd1,  CHK_BYTE,  8'h08},  // just below the blank range
        '{KIND_CHAR,  8'h0E, 6'd1,  CHK_BYTE,  8'h0E},  // just above it
        '{KIND_CHAR,  CH_GT, 6'd1,  CHK_BYTE,  CH_GT},
        '{KIND_CHAR,  CH_TAB, 6'd1, CHK_BYTE,  CH_TAB}, // first blank kept
        '{KIND_CHAR,  CH_CR, 6'd2,  CHK_MODEL, 8'h00},  // further blanks dropped
        '{KIND_CHAR,  8'h80, 6'd1,  CHK_MODEL, 8'h00},  // high byte starts text
        '{KIND_CHAR,  CH_SPACE, 6'd3, CHK_MODEL, 8'h00},
        '{KIND_CHAR,  8'h79, 6'd1,  CHK_MODEL, 8'h00},  // held run released
        '{KIND_CHAR,  8'h0B, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_FLUSH, 8'hFF, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  8'h0C, 6'd2,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  CH_LT, 6'd1,  CHK_MODEL, 8'h00},  // held run dropped before tag
        '{KIND_CHAR,  CH_SPACE, 6'd4, CHK_MODEL, 8'h00},
        '{KIND_CHAR,  8'h70, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  8'h0A, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  CH_GT, 6'd1,  CHK_MODEL, 8'h00},  // close from tag space
        '{KIND_CHAR,  CH_LT, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  CH_GT, 6'd1,  CHK_MODEL, 8'h00},  // close straight from tag
        '{KIND_CHAR,  8'h71, 6'd1,  CHK_MODEL, 8'h00},
        '{KIND_CHAR,  CH_SPACE, 6'd33, CHK_MODEL, 8'h00}, // hold buffer overflows
        '{KIND_CHAR,  CH_CR, 6'd32, CHK_MODEL, 8'h00},  // hold buffer exactly full
        '{KIND_FLUSH, 8'h00, 6'd1,  CHK_MODEL, 8'h00}
    };

    markup_whitespace_compactor #(
        .HOLD_DEPTH(HOLD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic blank_char(input logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] b, input logic ovf);
        step_out.push_back('{b, 1'b0, ovf});
    endfunction

    function automatic void release_run(input logic ovf);
        for (int i = 0; i < run_len; i++) emit(run_buf[i], ovf);
        run_len = 0;
    endfunction

    // next squeezer state and the bytes one item lets out
    function automatic void squeeze_step(input logic kind, input logic [7:0] c);
        logic ws;
        ws = blank_char(c);
        step_out.delete();
        if (kind == KIND_FLUSH) begin
            release_run(1'b0);
        end else begin
            case (sq_mode)
                MODE_START: begin
                    if (c == CH_LT) sq_mode = MODE_TAG;
                    else if (ws) sq_mode = MODE_FIRST_SPACE;
                    emit(c, 1'b0);
                end
                MODE_TAG: begin
                    if (ws) begin
                        emit(CH_SPACE, 1'b0);
                        sq_mode = MODE_TAG_SPACE;
                    end else begin
                        if (c == CH_GT) sq_mode = MODE_FIRST_SPACE;
                        emit(c, 1'b0);
                    end
                end
                MODE_TAG_SPACE: begin
                    if (!ws) begin
                        if (c == CH_GT) sq_mode = MODE_FIRST_SPACE;
                        else sq_mode = MODE_TAG;
                        emit(c, 1'b0);
                    end
                end
                MODE_FIRST_SPACE, MODE_MORE_SPACE: begin
                    if (ws) begin
                        if (sq_mode == MODE_FIRST_SPACE) begin
                            emit(c, 1'b0);
                            sq_mode = MODE_MORE_SPACE;
                        end
                    end else begin
                        if (c == CH_LT) sq_mode = MODE_TAG;
                        else sq_mode = MODE_TEXT;
                        emit(c, 1'b0);
                    end
                end
                MODE_TEXT: begin
                    if (ws) begin
                        if (run_len >= HOLD) begin
                            release_run(1'b1);
                            emit(c, 1'b1);
                        end else begin
                            run_buf[run_len] = c;
                            run_len++;
                        end
                    end else if (c == CH_LT) begin
                        run_len = 0;
                        sq_mode = MODE_TAG;
                        emit(c, 1'b0);
                    end else begin
                        release_run(1'b0);
                        emit(c, 1'b0);
                    end
                end
                default: sq_mode = MODE_START;
            endcase
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    // mostly short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 20);
    endfunction

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(0, 5);
        if (k == 5) return CH_SPACE;
        return CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] rand_text();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 9) return 8'($urandom_range(8'h80, 8'hFF));
        return CH_GT;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] c, input t_chk chk,
                             input logic [7:0] exp);
        int gap;
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_ch     <= c;
        item_chk <= chk;
        item_exp <= exp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        send_item(KIND_CHAR, c, CHK_MODEL, 8'h00);
    endtask

    // predict on accepted input, then check accepted output against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                squeeze_step(i_kind, i_ch);
                case (item_chk)
                    CHK_MODEL: foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
                    CHK_BYTE:  expected_bytes.push_back('{item_exp, 1'b1, 1'b0});
                    default:   ;
                endcase
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                got = '{o_out_byte, o_last, o_overflow};
                if (expected_bytes.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result byte %h last %b overflow %b, expected none",
                             $time, got.data, got.last, got.ovf);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last
                            || got.ovf !== want.ovf) begin
                        err_cnt++;
                        $display("%0t: expected byte %h last %b ovf %b, got %h %b %b",
                                 $time, want.data, want.last, want.ovf,
                                 got.data, got.last, got.ovf);
                    end
                end
            end
        end
    end

    // output back-pressure
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) n = 60;
            i_stall <= 1'b0;
            repeat (n + 1) @(posedge i_clk);
            n = idle_len();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int pick;
        int dir_items;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(DIR_TAB); r++) begin
            repeat (DIR_TAB[r].reps)
                send_item(DIR_TAB[r].kind, DIR_TAB[r].ch, DIR_TAB[r].chk, DIR_TAB[r].exp);
        end
        dir_items = items_sent;

        while (items_sent < dir_items + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // tag with blank runs inside
                push_char(CH_LT);
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        repeat ($urandom_range(1, 3)) push_char(rand_blank());
                    end else begin
                        push_char(8'h61 + 8'($urandom_range(0, 25)));
                    end
                end
                push_char(CH_GT);
            end else if (pick < 65) begin
                // text words separated by short runs
                push_char(rand_text());
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        repeat ($urandom_range(1, 4)) push_char(rand_blank());
                    end else begin
                        push_char(rand_text());
                    end
                end
            end else if (pick < 73) begin
                // long run around the hold depth
                push_char(rand_text());
                repeat ($urandom_range(HOLD - 4, HOLD + 8)) push_char(rand_blank());
                if ($urandom_range(0, 1) == 0) begin
                    send_item(KIND_FLUSH, 8'($urandom_range(0, 255)), CHK_MODEL, 8'h00);
                end else begin
                    push_char(rand_text());
                end
            end else if (pick < 83) begin
                send_item(KIND_FLUSH, 8'($urandom_range(0, 255)), CHK_MODEL, 8'h00);
            end else begin
                // raw noise
                repeat ($urandom_range(1, 4)) begin
                    send_item(($urandom_range(0, 7) == 0) ? KIND_FLUSH : KIND_CHAR,
                              8'($urandom_range(0, 255)), CHK_MODEL, 8'h00);
                end
            end
        end

        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: markup_whitespace_compactor.f
src/mwc_pkg.sv
src/mwc_ctrl.sv
src/mwc_dp.sv
src/markup_whitespace_compactor.sv
dv/tb_top.sv
